// ----- hdl/seven_segment_radix_display_scanner_top_assert.svh -----
// assertion macros used by the display scanner top module
`ifndef SEVEN_SEGMENT_RADIX_DISPLAY_SCANNER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_RADIX_DISPLAY_SCANNER_TOP_ASSERT_SVH

// clocked check, masked while reset is held
`define SSRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds through reset
`define SSRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/ssrd_pkg.sv -----
// types, constants and code tables for the seven-segment display scanner
package ssrd_pkg;

  // display geometry
  localparam int DIGIT_COUNT        = 4;
  localparam int NUMBER_STORE_DEPTH = 5;
  localparam int STRING_DEPTH       = 4;
  localparam int EnableW            = 4;

  localparam int PosW    = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int NumIdxW = (NUMBER_STORE_DEPTH > 1) ? $clog2(NUMBER_STORE_DEPTH) : 1;
  localparam int StrIdxW = 2;

  // field widths
  localparam int ValW  = 16;
  localparam int RadW  = 5;
  localparam int CodeW = 5;
  localparam int CharW = 8;
  localparam int SegW  = 8;
  localparam int RemW  = 4;

  // divider works four quotient bits per cycle
  localparam int DivBits  = 4;
  localparam int DivSteps = ValW / DivBits;
  localparam int DivCntW  = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  localparam logic [CodeW-1:0] BLANK_CODE = CodeW'(16);
  localparam logic [RadW-1:0]  RADIX_MIN  = RadW'(2);
  localparam logic [RadW-1:0]  RADIX_MAX  = RadW'(16);

  // stream payload widths
  localparam int InDataW  = 56;
  localparam int OutDataW = 16;

  typedef enum logic [1:0] {
    CMD_SCAN   = 2'd0,
    CMD_NUMBER = 2'd1,
    CMD_STRING = 2'd2
  } cmd_e;

  // divider start request
  typedef struct packed {
    logic            start;
    logic [ValW-1:0] dividend;
    logic [RadW-1:0] divisor;
  } ssrd_div_req_t;

  // divider result, valid while done is high
  typedef struct packed {
    logic            done;
    logic [ValW-1:0] quotient;
    logic [RemW-1:0] remainder;
  } ssrd_div_res_t;

  // segment pattern of a digit code, bit0 is segment a
  function automatic logic [SegW-1:0] code_pattern(input logic [CodeW-1:0] code);
    logic [SegW-1:0] pat;
    case (code)
      5'd0:    pat = 8'h3F;
      5'd1:    pat = 8'h06;
      5'd2:    pat = 8'h5B;
      5'd3:    pat = 8'h4F;
      5'd4:    pat = 8'h66;
      5'd5:    pat = 8'h6D;
      5'd6:    pat = 8'h7D;
      5'd7:    pat = 8'h07;
      5'd8:    pat = 8'h7F;
      5'd9:    pat = 8'h6F;
      5'd10:   pat = 8'h77;
      5'd11:   pat = 8'h7C;
      5'd12:   pat = 8'h58;
      5'd13:   pat = 8'h5E;
      5'd14:   pat = 8'h79;
      5'd15:   pat = 8'h71;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  // hex character to digit code, anything else blanks
  function automatic logic [CodeW-1:0] char_to_code(input logic [CharW-1:0] c);
    logic [CodeW-1:0] code;
    code = BLANK_CODE;
    if (c inside {[8'h41:8'h46]}) begin
      code = CodeW'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      code = CodeW'(c - 8'h57);
    end else if (c inside {[8'h30:8'h39]}) begin
      code = CodeW'(c - 8'h30);
    end
    return code;
  endfunction

endpackage

// ----- hdl/ssrd_div.sv -----
// shared radix divider: 16-bit value by a 5-bit radix, four quotient bits a cycle
module ssrd_div
  import ssrd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssrd_div_req_t req_i,
  output ssrd_div_res_t res_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ValW-1:0]    quo_q, quo_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [RadW-1:0]    dvs_q, dvs_d;
  logic [ValW-1:0]    step_quo;
  logic [RemW-1:0]    step_rem;

  // four restoring steps on the running remainder
  always_comb begin
    logic [RemW:0]   trial;
    logic [ValW-1:0] q;
    logic [RemW-1:0] r;
    logic            ge;
    q = quo_q;
    r = rem_q;
    for (int k = 0; k < DivBits; k++) begin
      trial = {r, q[ValW-1]};
      ge    = ({1'b0, trial} >= {1'b0, dvs_q});
      if (ge) begin
        r = RemW'(trial - dvs_q);
      end else begin
        r = trial[RemW-1:0];
      end
      q = {q[ValW-2:0], ge};
    end
    step_quo = q;
    step_rem = r;
  end

  // sequencing over the nibbles of the dividend
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = step_quo;
      rem_d = step_rem;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

// ----- hdl/seven_segment_radix_display_scanner_top.sv -----
// Four-digit multiplexed seven-segment scanner with number and string stores.
// Scan tick: result beat registered, valid the cycle after the tick is taken.
// Load string: written to the string store when taken. Load number: one digit
// per pass of the shared divider (1 to 5 digits), each pass four 4-bit steps.
// Reset: number store blank, string store blank/0/0/0, position 0, mode 0.
`include "seven_segment_radix_display_scanner_top_assert.svh"

module seven_segment_radix_display_scanner_top
  import ssrd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] number_value, [20:16] number_radix, [28:21] char_first,
  // [36:29] char_second, [44:37] char_third, [52:45] char_fourth, [55:53] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]          s_axis_tuser,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] digit_enable_n, [11:4] segment_drive_n, [15:12] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // display_mode register write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic                mode_q;
  logic [PosW-1:0]     pos_q;
  logic [NumIdxW-1:0]  dig_idx_q, dig_idx_d;
  logic [RadW-1:0]     rad_q, rad_d;
  logic [CodeW-1:0]    num_codes_q [NUMBER_STORE_DEPTH];
  logic [CodeW-1:0]    str_codes_q [STRING_DEPTH];
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic                s_fire;
  logic                scan_fire;
  logic                num_fire;
  logic                str_fire;
  logic                div_last;
  ssrd_div_req_t       div_req;
  ssrd_div_res_t       div_res;

  logic [ValW-1:0]     in_value;
  logic [RadW-1:0]     in_radix;
  logic [RadW-1:0]     radix_clamped;
  logic [CharW-1:0]    in_chars [STRING_DEPTH];

  logic [NumIdxW-1:0]  num_rd_idx;
  logic [StrIdxW-1:0]  str_rd_idx;
  logic [CodeW-1:0]    scan_code;
  logic [EnableW-1:0]  scan_enable_n;
  logic [SegW-1:0]     scan_seg_n;

  // unpack the input beat
  assign in_value    = s_axis_tdata[15:0];
  assign in_radix    = s_axis_tdata[20:16];
  assign in_chars[0] = s_axis_tdata[28:21];
  assign in_chars[1] = s_axis_tdata[36:29];
  assign in_chars[2] = s_axis_tdata[44:37];
  assign in_chars[3] = s_axis_tdata[52:45];

  assign radix_clamped = (in_radix < RADIX_MIN) ? RADIX_MIN :
                         (in_radix > RADIX_MAX) ? RADIX_MAX : in_radix;

  // handshake
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign scan_fire     = s_fire && (s_axis_tuser == CMD_SCAN);
  assign num_fire      = s_fire && (s_axis_tuser == CMD_NUMBER);
  assign str_fire      = s_fire && (s_axis_tuser == CMD_STRING);
  assign cfg_ready_o   = 1'b1;

  // digit loop ends on a zero quotient or a full store
  assign div_last = (div_res.quotient == '0) ||
                    (dig_idx_q == NumIdxW'(NUMBER_STORE_DEPTH - 1));

  // digit sequencer around the shared divider
  always_comb begin
    state_d          = state_q;
    dig_idx_d        = dig_idx_q;
    rad_d            = rad_q;
    div_req.start    = 1'b0;
    div_req.dividend = div_res.quotient;
    div_req.divisor  = rad_q;
    case (state_q)
      ST_IDLE: begin
        if (num_fire) begin
          state_d          = ST_DIV;
          dig_idx_d        = '0;
          rad_d            = radix_clamped;
          div_req.start    = 1'b1;
          div_req.dividend = in_value;
          div_req.divisor  = radix_clamped;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_last) begin
            state_d = ST_IDLE;
          end else begin
            dig_idx_d     = dig_idx_q + 1'b1;
            div_req.start = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  ssrd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dig_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      dig_idx_q <= dig_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
  end

  // display mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // number store: blanked on load, then one digit per divider pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUMBER_STORE_DEPTH; i++) begin
        num_codes_q[i] <= BLANK_CODE;
      end
    end else if (num_fire) begin
      for (int i = 0; i < NUMBER_STORE_DEPTH; i++) begin
        num_codes_q[i] <= BLANK_CODE;
      end
    end else if ((state_q == ST_DIV) && div_res.done) begin
      num_codes_q[dig_idx_q] <= CodeW'(div_res.remainder);
    end
  end

  // string store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_codes_q[0] <= BLANK_CODE;
      for (int i = 1; i < STRING_DEPTH; i++) begin
        str_codes_q[i] <= '0;
      end
    end else if (str_fire) begin
      for (int i = 0; i < STRING_DEPTH; i++) begin
        str_codes_q[i] <= char_to_code(in_chars[i]);
      end
    end
  end

  // code at the current scan position
  assign num_rd_idx = NumIdxW'(pos_q);
  assign str_rd_idx = StrIdxW'(STRING_DEPTH - 1) - StrIdxW'(pos_q);

  always_comb begin
    scan_code = BLANK_CODE;
    if (!mode_q) begin
      if (32'(pos_q) < NUMBER_STORE_DEPTH) begin
        scan_code = num_codes_q[num_rd_idx];
      end
    end else begin
      if (32'(pos_q) < STRING_DEPTH) begin
        scan_code = str_codes_q[str_rd_idx];
      end
    end
  end

  // active-low enable, all high past the fourth position
  always_comb begin
    for (int k = 0; k < EnableW; k++) begin
      scan_enable_n[k] = (32'(pos_q) != k);
    end
  end

  assign scan_seg_n = ~code_pattern(scan_code);

  // scan position advances on each tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (scan_fire) begin
      if (pos_q == PosW'(DIGIT_COUNT - 1)) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (scan_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_fire) begin
      m_data_q <= {{(OutDataW - EnableW - SegW){1'b0}}, scan_seg_n, scan_enable_n};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  `SSRD_ASSERT(a_done_only_in_div, div_res.done |-> (state_q == ST_DIV), "divider done outside digit loop")
  `SSRD_ASSERT(a_digit_index_range, (state_q == ST_DIV) |-> (32'(dig_idx_q) < NUMBER_STORE_DEPTH), "digit index beyond store")
  `SSRD_ASSERT(a_pos_moves_on_tick, (pos_q != $past(pos_q)) |-> $past(scan_fire), "scan position moved without a tick")
  `SSRD_ASSERT(a_out_from_tick, $rose(m_valid_q) |-> $past(scan_fire), "output beat without a scan tick")

endmodule
